// ----- rtl/tels_pkg.sv -----
// ----------------------------------------------------------------------------
// tels_pkg: shared types and constants of the timed event LED scheduler
// Entry, payload and cell control types, cell operation codes, sequencer
// states and the reset value of the flash duration register.
// ----------------------------------------------------------------------------
package tels_pkg;

	localparam logic [31:0] FLASH_RESET_US = 32'(150 * 1000);

	localparam int TIME_W = 32;
	localparam int TAG_W  = 8;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_TICK   = 1'b1
	} cmd_t;

	// one queued event; rgb bit0 red, bit1 green, bit2 blue
	typedef struct packed {
		logic [TIME_W-1:0] time_us;
		logic [2:0]        rgb;
		logic [TAG_W-1:0]  tag;
	} entry_t;

	typedef enum logic [1:0] {
		OP_HOLD = 2'd0,
		OP_PUT  = 2'd1,
		OP_DROP = 2'd2
	} cell_op_t;

	// broadcast to every cell of the row
	typedef struct packed {
		cell_op_t op;
		entry_t   entry;
	} cell_ctrl_t;

	typedef struct packed {
		logic              cmd;
		logic [TIME_W-1:0] event_time;
		logic              event_red;
		logic              event_green;
		logic              event_blue;
		logic [TAG_W-1:0]  event_tag;
		logic [TIME_W-1:0] now_time;
	} in_item_t;

	typedef struct packed {
		logic             insert_ok;
		logic             red_on;
		logic             green_on;
		logic             blue_on;
		logic [1:0]       fired_count;
		logic [TAG_W-1:0] fired_tag;
		logic [6:0]       queue_level;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE    = 3'd0,
		ST_PUT     = 3'd1,
		ST_STAGE1  = 3'd2,
		ST_STAGE2  = 3'd3,
		ST_OFF_PUT = 3'd4,
		ST_DROP    = 3'd5,
		ST_DONE    = 3'd6
	} seq_state_t;

endpackage

// ----- rtl/tels_cell.sv -----
// ----------------------------------------------------------------------------
// tels_cell: one slot of the sorted event row
// Holds one entry; on a put it shifts toward the tail or takes the new entry,
// on a drop it takes its tail-side neighbor.
// ----------------------------------------------------------------------------
module tels_cell (
	input  logic                 clk,
	input  tels_pkg::cell_ctrl_t ctrl,
	input  logic                 occupied,
	input  tels_pkg::entry_t     prev_entry,
	input  logic                 prev_take,
	input  tels_pkg::entry_t     next_entry,
	output tels_pkg::entry_t     entry,
	output logic                 take
);

	tels_pkg::entry_t entry_q;
	tels_pkg::entry_t entry_d;

	// new entry belongs here or earlier: slot empty or held time is later
	assign take  = !occupied || (ctrl.entry.time_us < entry_q.time_us);
	assign entry = entry_q;

	always_comb begin
		entry_d = entry_q;
		case (ctrl.op)
			tels_pkg::OP_PUT: begin
				if (prev_take) begin
					entry_d = prev_entry;
				end else if (take) begin
					entry_d = ctrl.entry;
				end
			end
			tels_pkg::OP_DROP: entry_d = next_entry;
			default: entry_d = entry_q;
		endcase
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

endmodule

// ----- rtl/timed_event_led_scheduler.sv -----
// Sequence: an insert passes the put state and then done; a tick runs stage one,
// stage two and done, plus a head drop per fired event and, before that drop, an
// off-event put when the event is lit and the row is not full. One transaction in
// flight; the next input is taken the cycle after the result enters the output
// register, and done waits while the output register is held.
// Reset: queue empty, alarm disarmed, LEDs off, flash 150000 us, cells undefined.
// ----------------------------------------------------------------------------
// timed_event_led_scheduler: time-sorted RGB event queue with alarm
// A row of QUEUE_DEPTH cells keeps events sorted by time. A sequencer runs
// inserts and the tick stages (alarm fire, due fire, alarm arm) over the row.
// ----------------------------------------------------------------------------
module timed_event_led_scheduler #(
	parameter int QUEUE_DEPTH = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  tels_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output tels_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [31:0]         cfg_data
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	// sequencer
	tels_pkg::seq_state_t state_q, state_d;
	tels_pkg::cell_ctrl_t ctrl;
	logic                 fire;   // head fires this cycle
	logic                 arm;    // alarm armed with head time this cycle

	// control state
	logic [CW-1:0]  count_q;
	logic           armed_q;
	logic [31:0]    alarm_q;
	logic [2:0]     led_q;
	logic [31:0]    flash_q;
	logic           out_valid_q;

	// per-transaction working registers
	logic [31:0]         now_q;
	tels_pkg::entry_t    ins_q;     // entry waiting to be put into the row
	logic [1:0]          cnt_q;
	logic [7:0]          tag_q;
	logic                fired_q;
	logic                ok_q;
	logic                last_q;    // current fire came from stage two
	tels_pkg::out_item_t out_q;

	// cell row
	tels_pkg::entry_t         entries [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0]   takes;
	tels_pkg::entry_t         head;
	logic                     full;
	logic                     empty;

	assign head  = entries[0];
	assign full  = (count_q == CW'(QUEUE_DEPTH));
	assign empty = (count_q == '0);

	genvar gi;
	generate
		for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
			tels_pkg::entry_t prev_e;
			tels_pkg::entry_t next_e;
			logic             prev_t;
			logic             occ;

			assign occ = (count_q > CW'(gi));

			if (gi == 0) begin : g_first
				assign prev_e = ctrl.entry;
				assign prev_t = 1'b0;
			end else begin : g_mid
				assign prev_e = entries[gi-1];
				assign prev_t = takes[gi-1];
			end

			if (gi == QUEUE_DEPTH - 1) begin : g_last
				assign next_e = entries[gi];
			end else begin : g_inner
				assign next_e = entries[gi+1];
			end

			tels_cell u_cell (
				.clk        (clk),
				.ctrl       (ctrl),
				.occupied   (occ),
				.prev_entry (prev_e),
				.prev_take  (prev_t),
				.next_entry (next_e),
				.entry      (entries[gi]),
				.take       (takes[gi])
			);
		end
	endgenerate

	assign in_ready  = (state_q == tels_pkg::ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign cfg_ready = 1'b1;

	// ---------------------------------------------------------------- FSM
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tels_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		ctrl.op    = tels_pkg::OP_HOLD;
		ctrl.entry = ins_q;
		fire       = 1'b0;
		arm        = 1'b0;
		case (state_q)
			tels_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = (in_data.cmd == tels_pkg::CMD_TICK) ?
						tels_pkg::ST_STAGE1 : tels_pkg::ST_PUT;
				end
			end
			tels_pkg::ST_PUT: begin
				if (!full) begin
					ctrl.op = tels_pkg::OP_PUT;
				end
				state_d = tels_pkg::ST_DONE;
			end
			tels_pkg::ST_STAGE1: begin
				// alarm stage
				if (armed_q && (now_q >= alarm_q)) begin
					fire    = 1'b1;
					state_d = (head.rgb != 3'b000 && !full) ?
						tels_pkg::ST_OFF_PUT : tels_pkg::ST_DROP;
				end else begin
					state_d = tels_pkg::ST_STAGE2;
				end
			end
			tels_pkg::ST_STAGE2: begin
				// due-head stage, then arming when nothing fired
				if (!empty && (head.time_us <= now_q)) begin
					fire    = 1'b1;
					state_d = (head.rgb != 3'b000 && !full) ?
						tels_pkg::ST_OFF_PUT : tels_pkg::ST_DROP;
				end else begin
					if (!fired_q && !empty && (!armed_q || head.time_us < alarm_q)) begin
						arm = 1'b1;
					end
					state_d = tels_pkg::ST_DONE;
				end
			end
			tels_pkg::ST_OFF_PUT: begin
				ctrl.op = tels_pkg::OP_PUT;
				state_d = tels_pkg::ST_DROP;
			end
			tels_pkg::ST_DROP: begin
				ctrl.op = tels_pkg::OP_DROP;
				state_d = last_q ? tels_pkg::ST_DONE : tels_pkg::ST_STAGE2;
			end
			tels_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = tels_pkg::ST_IDLE;
				end
			end
			default: state_d = tels_pkg::ST_IDLE;
		endcase
	end

	// ------------------------------------------------------ control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			armed_q     <= 1'b0;
			alarm_q     <= '0;
			led_q       <= 3'b000;
			flash_q     <= tels_pkg::FLASH_RESET_US;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				flash_q <= cfg_data;
			end

			case (ctrl.op)
				tels_pkg::OP_PUT:  count_q <= count_q + CW'(1);
				tels_pkg::OP_DROP: begin
					if (!empty) begin
						count_q <= count_q - CW'(1);
					end
				end
				default: count_q <= count_q;
			endcase

			if (fire) begin
				led_q   <= head.rgb;
				armed_q <= 1'b0;
				alarm_q <= '0;
			end else if (arm) begin
				armed_q <= 1'b1;
				alarm_q <= head.time_us;
			end

			if (state_q == tels_pkg::ST_DONE && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ------------------------------------------------- transaction payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			now_q         <= in_data.now_time;
			ins_q.time_us <= in_data.event_time;
			ins_q.rgb     <= {in_data.event_blue, in_data.event_green, in_data.event_red};
			ins_q.tag     <= in_data.event_tag;
			cnt_q         <= 2'd0;
			tag_q         <= 8'd0;
			fired_q       <= 1'b0;
			ok_q          <= 1'b0;
			last_q        <= 1'b0;
		end

		if (state_q == tels_pkg::ST_PUT) begin
			ok_q <= !full;
		end

		// fired head: latch its tag and stage the all-off event
		if (fire) begin
			tag_q         <= head.tag;
			cnt_q         <= cnt_q + 2'd1;
			fired_q       <= 1'b1;
			last_q        <= (state_q == tels_pkg::ST_STAGE2);
			ins_q.time_us <= now_q + flash_q;
			ins_q.rgb     <= 3'b000;
			ins_q.tag     <= 8'd0;
		end

		if (state_q == tels_pkg::ST_DONE && (!out_valid_q || out_ready)) begin
			out_q.insert_ok   <= ok_q;
			out_q.red_on      <= led_q[0];
			out_q.green_on    <= led_q[1];
			out_q.blue_on     <= led_q[2];
			out_q.fired_count <= cnt_q;
			out_q.fired_tag   <= tag_q;
			out_q.queue_level <= 7'(count_q);
		end
	end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench of the timed event LED scheduler
// A clocked driver sends insert and tick transactions from a pending queue.
// A predictor keeps a copy of the sorted event queue, alarm and LEDs, and
// produces one expected result per accepted transaction. A clocked monitor
// compares every result field with the oldest expectation. The run has a
// directed opening and then four random phases. Each phase uses its own
// flash duration and its own mix of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int SLOTS = 64;
	localparam int PHASE_ITEMS = 500;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                in_valid = 1'b0;
	logic                in_ready;
	tels_pkg::in_item_t  in_data = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	tels_pkg::out_item_t out_data;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [31:0]         cfg_data = '0;

	timed_event_led_scheduler #(
		.QUEUE_DEPTH(SLOTS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// ------------------------------------------------------------------
	// Predicted scheduler state
	// ------------------------------------------------------------------
	tels_pkg::entry_t sched_slots [SLOTS];
	int               sched_held = 0;
	logic             alarm_on = 1'b0;
	logic [31:0]      alarm_at = '0;
	logic [2:0]       lamp_rgb = '0;
	logic [31:0]      flash_us = tels_pkg::FLASH_RESET_US;

	tels_pkg::in_item_t  pending_items [$];   // transactions not yet driven
	tels_pkg::out_item_t due_results [$];     // expected results, oldest first
	tels_pkg::out_item_t due_now;

	logic in_taken = 1'b0;
	logic cfg_taken = 1'b0;
	int   send_idle_pct = 0;
	int   stall_pct = 0;
	int   errors = 0;
	int   result_no = 0;
	int   items_made = 0;

	// Sorted insert: new entry goes after every entry with equal or earlier time.
	function automatic logic slots_put(logic [31:0] t, logic [2:0] rgb, logic [7:0] tag);
		int pos;
		int i;
		if (sched_held >= SLOTS)
			return 1'b0;
		pos = sched_held;
		// entries later than t form a suffix; keep the lowest index of it
		for (i = sched_held - 1; i >= 0; i--)
			if (t < sched_slots[i].time_us)
				pos = i;
		for (i = sched_held; i > pos; i--)
			sched_slots[i] = sched_slots[i - 1];
		sched_slots[pos].time_us = t;
		sched_slots[pos].rgb = rgb;
		sched_slots[pos].tag = tag;
		sched_held++;
		return 1'b1;
	endfunction

	// Fire the head: LEDs follow it, a lit event schedules its all-off event,
	// then the head slot is removed. The off event may itself land in front
	// (time wrap) and is then the entry removed.
	function automatic logic [7:0] fire_head(logic [31:0] now);
		tels_pkg::entry_t head;
		int i;
		head = sched_slots[0];
		lamp_rgb = head.rgb;
		if (head.rgb != 3'b000)
			void'(slots_put(now + flash_us, 3'b000, 8'h00));
		if (sched_held > 0) begin
			for (i = 0; i + 1 < sched_held; i++)
				sched_slots[i] = sched_slots[i + 1];
			sched_held--;
		end
		alarm_on = 1'b0;
		alarm_at = '0;
		return head.tag;
	endfunction

	function automatic tels_pkg::out_item_t sched_step(tels_pkg::in_item_t it);
		tels_pkg::out_item_t r;
		logic       fired;
		logic [1:0] n_fired;
		logic [7:0] last_tag;
		r = '0;
		fired = 1'b0;
		n_fired = 2'd0;
		last_tag = 8'h00;
		if (it.cmd == tels_pkg::CMD_INSERT) begin
			r.insert_ok = slots_put(it.event_time,
				{it.event_blue, it.event_green, it.event_red}, it.event_tag);
		end else begin
			// alarm stage
			if (alarm_on && it.now_time >= alarm_at) begin
				last_tag = fire_head(it.now_time);
				n_fired++;
				fired = 1'b1;
			end
			// due stage
			if (sched_held > 0 && sched_slots[0].time_us <= it.now_time) begin
				last_tag = fire_head(it.now_time);
				n_fired++;
				fired = 1'b1;
			end
			// arm stage
			if (!fired && sched_held > 0) begin
				if (!alarm_on || sched_slots[0].time_us < alarm_at) begin
					alarm_on = 1'b1;
					alarm_at = sched_slots[0].time_us;
				end
			end
		end
		r.red_on = lamp_rgb[0];
		r.green_on = lamp_rgb[1];
		r.blue_on = lamp_rgb[2];
		r.fired_count = n_fired;
		r.fired_tag = last_tag;
		r.queue_level = 7'(sched_held);
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------
	task automatic report_mismatch(string msg);
		errors++;
		$display("%0t ns mismatch: %s", $time, msg);
	endtask

	task automatic cmp_field(string field, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d %s got %0h want %0h",
				result_no, field, got, want));
	endtask

	// Monitor: outputs sampled at the rising edge. The result is checked
	// before a new expectation is queued so a stray result never meets the
	// expectation of a transaction accepted on the same edge.
	always @(posedge clk) begin
		in_taken <= in_valid && in_ready;
		cfg_taken <= cfg_valid && cfg_ready;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (due_results.size() == 0) begin
					report_mismatch("result with no transaction waiting");
				end else begin
					due_now = due_results.pop_front();
					cmp_field("insert_ok", 32'(out_data.insert_ok),
						32'(due_now.insert_ok));
					cmp_field("red_on", 32'(out_data.red_on), 32'(due_now.red_on));
					cmp_field("green_on", 32'(out_data.green_on), 32'(due_now.green_on));
					cmp_field("blue_on", 32'(out_data.blue_on), 32'(due_now.blue_on));
					cmp_field("fired_count", 32'(out_data.fired_count),
						32'(due_now.fired_count));
					cmp_field("fired_tag", 32'(out_data.fired_tag),
						32'(due_now.fired_tag));
					cmp_field("queue_level", 32'(out_data.queue_level),
						32'(due_now.queue_level));
				end
				result_no++;
			end
			if (in_valid && in_ready)
				due_results.push_back(sched_step(in_data));
			if (cfg_valid && cfg_ready)
				flash_us = cfg_data;
		end
	end

	// Driver: inputs change at the falling edge. A held transaction stays
	// until accepted; a new one is offered only after the previous is taken.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					in_data <= pending_items.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	function automatic logic [2:0] pick_rgb();
		if ($urandom_range(3) == 0)
			return 3'b000;
		return 3'($urandom_range(1, 7));
	endfunction

	task automatic add_insert(logic [31:0] t, logic [2:0] rgb, logic [7:0] tag);
		tels_pkg::in_item_t it;
		it.cmd = tels_pkg::CMD_INSERT;
		it.event_time = t;
		it.event_red = rgb[0];
		it.event_green = rgb[1];
		it.event_blue = rgb[2];
		it.event_tag = tag;
		it.now_time = $urandom;     // unused on insert
		pending_items.push_back(it);
		items_made++;
	endtask

	task automatic add_tick(logic [31:0] now);
		tels_pkg::in_item_t it;
		it.cmd = tels_pkg::CMD_TICK;
		it.event_time = $urandom;   // unused on tick
		{it.event_blue, it.event_green, it.event_red} = 3'($urandom);
		it.event_tag = 8'($urandom);
		it.now_time = now;
		pending_items.push_back(it);
		items_made++;
	endtask

	// Waits until every transaction is driven and answered, then lets the
	// sequencer settle before anything touches the register.
	task automatic wait_idle();
		while (pending_items.size() != 0 || in_valid || due_results.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_flash(logic [31:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(negedge clk);
		while (!cfg_taken)
			@(negedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		int          ph;
		int          pick;
		int          n;
		logic [31:0] gen_now;
		logic [31:0] flash_next;

		// directed opening, default flash duration of 150000 us
		add_tick(32'd0);                                // empty queue, nothing happens
		add_insert(32'hFFFF_FFFF, 3'b111, 8'hFF);
		add_insert(32'd0, 3'b000, 8'h00);
		add_insert(32'd100, 3'b001, 8'h01);
		add_insert(32'd100, 3'b010, 8'h02);             // equal time sorts after
		add_tick(32'd0);                                // dark event due, no off event
		add_tick(32'd50);                               // arms the alarm at 100
		add_insert(32'd60, 3'b100, 8'h03);              // earlier than the alarm
		add_tick(32'd55);                               // alarm moves to 60
		add_tick(32'd100);                              // alarm fire plus due fire
		add_tick(32'd100);
		add_tick(32'd150100);                           // off events come due
		add_tick(32'd150100);
		add_tick(32'd150100);
		add_tick(32'hFFFF_FFFE);                        // arm at the top of time
		add_tick(32'hFFFF_FFFF);                        // off event wraps ahead of head
		add_insert(32'hFFFF_FFFF, 3'b101, 8'h80);
		add_tick(32'hFFFF_FFFF);
		add_insert(32'd7, 3'b110, 8'h7F);
		add_tick(32'd3);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		wait_idle();

		for (ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					flash_next = 32'd0;
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					flash_next = 32'hFFFF_FFFF;
					send_idle_pct = 75;
					stall_pct = 0;
				end
				2: begin
					flash_next = $urandom_range(1, 2000);
					send_idle_pct = 0;
					stall_pct = 75;
				end
				default: begin
					flash_next = $urandom;
					send_idle_pct = 19;
					stall_pct = 19;
				end
			endcase
			write_flash(flash_next);

			items_made = 0;
			gen_now = $urandom_range(0, 100000);
			while (items_made < PHASE_ITEMS) begin
				pick = $urandom_range(99);
				if (pick < 35) begin
					// a few events a little ahead of now
					n = $urandom_range(1, 6);
					repeat (n) add_insert(gen_now + $urandom_range(3000), pick_rgb(),
						8'($urandom));
				end else if (pick < 70) begin
					// time moves forward, repeated times allowed
					n = $urandom_range(1, 6);
					repeat (n) begin
						gen_now = gen_now + $urandom_range(1500);
						add_tick(gen_now);
					end
				end else if (pick < 77) begin
					// burst past the queue size: rejects and dropped off events
					n = $urandom_range(60, 70);
					repeat (n) add_insert(gen_now + $urandom_range(20000), pick_rgb(),
						8'($urandom));
				end else if (pick < 83) begin
					// drain at the end of time, then restart low
					n = $urandom_range(20, 40);
					repeat (n) add_tick(32'hFFFF_FFFF);
					gen_now = $urandom_range(5000);
				end else if (pick < 90) begin
					gen_now = 32'hFFFF_FFFF - $urandom_range(8000);
				end else begin
					// noise
					n = $urandom_range(1, 4);
					repeat (n) begin
						if ($urandom_range(1) == 1)
							add_tick($urandom);
						else
							add_insert($urandom, 3'($urandom), 8'($urandom));
					end
				end
			end
			wait_idle();
		end

		if (due_results.size() != 0)
			report_mismatch("expected results left over");
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		#3_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
